[design/itaf_pkg.sv]
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, codes, microcode table and character helpers for the
// integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

    // Conversion kinds
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_LHEX = 3'd2;
    localparam logic [2:0] OP_UHEX = 3'd3;
    localparam logic [2:0] OP_PTR  = 3'd4;

    // Digit counts and iteration counts
    localparam logic [4:0] DABBLE_STEPS = 5'd16;  // 32 bits, two per step
    localparam logic [4:0] DEC_DIGITS   = 5'd10;
    localparam logic [4:0] HEX32_DIGITS = 5'd8;
    localparam logic [4:0] HEX64_DIGITS = 5'd16;

    // ASCII constants
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    // Microprogram step addresses
    localparam logic [3:0] STEP_IDLE   = 4'd0;
    localparam logic [3:0] STEP_DISP   = 4'd1;
    localparam logic [3:0] STEP_DABBLE = 4'd2;
    localparam logic [3:0] STEP_BCD    = 4'd3;
    localparam logic [3:0] STEP_SIGN   = 4'd4;
    localparam logic [3:0] STEP_MINUS  = 4'd5;
    localparam logic [3:0] STEP_PTRCHK = 4'd6;
    localparam logic [3:0] STEP_PFX0   = 4'd7;
    localparam logic [3:0] STEP_PFXX   = 4'd8;
    localparam logic [3:0] STEP_SKIP   = 4'd9;
    localparam logic [3:0] STEP_DIGIT  = 4'd10;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_BAD_OP,
        COND_NOT_DEC,
        COND_CNT_MORE,
        COND_NOT_NEG,
        COND_NOT_PTR,
        COND_LEAD_ZERO
    } t_cond;

    // Character source for emit steps
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_MINUS,
        EMIT_ZERO,
        EMIT_X,
        EMIT_DIGIT
    } t_emit;

    // Datapath actions
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DABBLE,
        ACT_BCD,
        ACT_SHIFT,
        ACT_SKIP
    } t_act;

    typedef struct packed {
        t_cond      cond;
        logic [3:0] tgt_true;
        logic [3:0] tgt_false;
        t_emit      emit;
        t_act       act;
    } t_uword;

    typedef struct packed {
        t_act act;
    } t_dp_ctrl;

    typedef struct packed {
        logic       cnt_more;   // more than one digit/iteration left
        logic       top_zero;   // leading nibble is zero
        logic       neg;
        logic       dec;
        logic       ptr;
        logic       upper;
        logic [3:0] nibble;
    } t_dp_status;

    function automatic t_uword mk(t_cond c, logic [3:0] t, logic [3:0] f,
                                  t_emit e, t_act a);
        t_uword w;
        w.cond      = c;
        w.tgt_true  = t;
        w.tgt_false = f;
        w.emit      = e;
        w.act       = a;
        return w;
    endfunction

    // Control store
    function automatic t_uword itaf_rom(logic [3:0] pc);
        t_uword w;
        unique case (pc)
            STEP_IDLE:   w = mk(COND_BAD_OP, STEP_IDLE, STEP_DISP, EMIT_NONE, ACT_LOAD);
            STEP_DISP:   w = mk(COND_NOT_DEC, STEP_SIGN, STEP_DABBLE, EMIT_NONE, ACT_NONE);
            STEP_DABBLE: w = mk(COND_CNT_MORE, STEP_DABBLE, STEP_BCD, EMIT_NONE,
                                ACT_DABBLE);
            STEP_BCD:    w = mk(COND_ALWAYS, STEP_SIGN, STEP_SIGN, EMIT_NONE, ACT_BCD);
            STEP_SIGN:   w = mk(COND_NOT_NEG, STEP_PTRCHK, STEP_MINUS, EMIT_NONE, ACT_NONE);
            STEP_MINUS:  w = mk(COND_ALWAYS, STEP_PTRCHK, STEP_PTRCHK, EMIT_MINUS,
                                ACT_NONE);
            STEP_PTRCHK: w = mk(COND_NOT_PTR, STEP_SKIP, STEP_PFX0, EMIT_NONE, ACT_NONE);
            STEP_PFX0:   w = mk(COND_ALWAYS, STEP_PFXX, STEP_PFXX, EMIT_ZERO, ACT_NONE);
            STEP_PFXX:   w = mk(COND_ALWAYS, STEP_SKIP, STEP_SKIP, EMIT_X, ACT_NONE);
            STEP_SKIP:   w = mk(COND_LEAD_ZERO, STEP_SKIP, STEP_DIGIT, EMIT_NONE, ACT_SKIP);
            STEP_DIGIT:  w = mk(COND_CNT_MORE, STEP_DIGIT, STEP_IDLE, EMIT_DIGIT,
                                ACT_SHIFT);
            default:     w = mk(COND_ALWAYS, STEP_IDLE, STEP_IDLE, EMIT_NONE, ACT_NONE);
        endcase
        return w;
    endfunction

    // One double-dabble step: correct each BCD digit, then shift a bit in
    function automatic logic [39:0] dabble(logic [39:0] b, logic bin);
        logic [39:0] c;
        c = b;
        for (int i = 0; i < 10; i++) begin
            if (c[i*4 +: 4] >= 4'd5) begin
                c[i*4 +: 4] = c[i*4 +: 4] + 4'd3;
            end
        end
        return {c[38:0], bin};
    endfunction

    // Digit value to ASCII
    function automatic logic [7:0] hex_char(logic [3:0] n, logic upper);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = CH_ZERO + {4'd0, n};
        end else if (upper) begin
            r = CH_UPA + {4'd0, n} - 8'd10;
        end else begin
            r = CH_LOWA + {4'd0, n} - 8'd10;
        end
        return r;
    endfunction

endpackage

[design/itaf_datapath.sv]
// ----------------------------------------------------------------------------
// itaf_datapath
// Digit datapath: binary source, BCD/hex nibble shifter, digit counter and
// conversion flags, driven one action per step by the sequencer.
// ----------------------------------------------------------------------------
module itaf_datapath (
    input  logic                   i_clk,
    input  itaf_pkg::t_dp_ctrl     i_ctrl,
    input  logic [2:0]             i_operation,
    input  logic [63:0]            i_value,
    output itaf_pkg::t_dp_status   o_status
);
    import itaf_pkg::*;

    logic [63:0] r_sh,  n_sh;
    logic [31:0] r_bin, n_bin;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic        r_dec, n_dec;
    logic        r_ptr, n_ptr;
    logic        r_upper, n_upper;

    logic [31:0] low;
    logic [39:0] bcd_one;
    logic [39:0] bcd_two;

    assign low     = i_value[31:0];
    assign bcd_one = dabble(r_sh[39:0], r_bin[31]);
    assign bcd_two = dabble(bcd_one, r_bin[30]);

    // Next-state selection per action
    always_comb begin
        n_sh    = r_sh;
        n_bin   = r_bin;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_dec   = r_dec;
        n_ptr   = r_ptr;
        n_upper = r_upper;
        unique case (i_ctrl.act)
            ACT_LOAD: begin
                n_neg   = (i_operation == OP_SDEC) && low[31];
                n_dec   = (i_operation == OP_SDEC) || (i_operation == OP_UDEC);
                n_ptr   = (i_operation == OP_PTR);
                n_upper = (i_operation == OP_UHEX);
                n_bin   = ((i_operation == OP_SDEC) && low[31]) ? (~low + 32'd1) : low;
                if (i_operation == OP_PTR) begin
                    n_sh  = i_value;
                    n_cnt = HEX64_DIGITS;
                end else if ((i_operation == OP_SDEC) || (i_operation == OP_UDEC)) begin
                    n_sh  = 64'd0;
                    n_cnt = DABBLE_STEPS;
                end else begin
                    n_sh  = {low, 32'd0};
                    n_cnt = HEX32_DIGITS;
                end
            end
            ACT_DABBLE: begin
                n_sh  = {24'd0, bcd_two};
                n_bin = {r_bin[29:0], 2'b00};
                n_cnt = r_cnt - 5'd1;
            end
            ACT_BCD: begin
                n_sh  = {r_sh[39:0], 24'd0};
                n_cnt = DEC_DIGITS;
            end
            ACT_SHIFT: begin
                n_sh  = {r_sh[59:0], 4'd0};
                n_cnt = r_cnt - 5'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sh    <= n_sh;
        r_bin   <= n_bin;
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_dec   <= n_dec;
        r_ptr   <= n_ptr;
        r_upper <= n_upper;
    end

    // Status back to the sequencer
    assign o_status.cnt_more = (r_cnt != 5'd1);
    assign o_status.top_zero = (r_sh[63:60] == 4'd0);
    assign o_status.neg      = r_neg;
    assign o_status.dec      = r_dec;
    assign o_status.ptr      = r_ptr;
    assign o_status.upper    = r_upper;
    assign o_status.nibble   = r_sh[63:60];

endmodule

[design/integer_to_ascii_formatter_core.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one integer per request as ASCII text, one character per output
// request, most significant first, with o_last on the final character.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_ready carry i_operation and i_value. o_ready is
// high only while the sequencer sits at its idle step, so one number is
// worked on at a time. Unused operation codes are taken and dropped.
// Output channel: o_valid/i_ready carry o_character and o_last from an
// output register; the sequencer keeps working on non-emitting steps while
// a character waits and holds on the next emit step until it is taken.
// Control runs from an 11-step microcode table, one step per cycle, but the
// idle step waits for a request and an emit step for room in the output
// register. Decimal first runs double dabble (two bits per step); every form
// then skips leading zero digits one per cycle.
// Reset (i_rst_n low, synchronous) returns to the idle step and empties the
// output register; a number in flight is abandoned.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_character,
    output logic        o_last
);
    import itaf_pkg::*;

    logic [3:0] r_pc, n_pc;
    logic       r_o_valid, n_o_valid;
    logic [7:0] r_character, n_character;
    logic       r_last, n_last;

    t_uword     uw;
    t_dp_ctrl   dp_ctrl;
    t_dp_status st;
    logic       out_free;
    logic       fire;
    logic       cond_true;
    logic       bad_op;

    assign uw       = itaf_rom(r_pc);
    assign out_free = !r_o_valid || i_ready;
    assign bad_op   = (i_operation > OP_PTR);

    // Step completion: idle waits for a request, emit steps wait for room
    always_comb begin
        if (r_pc == STEP_IDLE) begin
            fire = i_valid;
        end else if (uw.emit != EMIT_NONE) begin
            fire = out_free;
        end else begin
            fire = 1'b1;
        end
    end

    // Jump condition
    always_comb begin
        unique case (uw.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_BAD_OP:    cond_true = bad_op;
            COND_NOT_DEC:   cond_true = !st.dec;
            COND_CNT_MORE:  cond_true = st.cnt_more;
            COND_NOT_NEG:   cond_true = !st.neg;
            COND_NOT_PTR:   cond_true = !st.ptr;
            COND_LEAD_ZERO: cond_true = st.top_zero && st.cnt_more;
            default:        cond_true = 1'b1;
        endcase
    end

    // Step counter
    assign n_pc = fire ? (cond_true ? uw.tgt_true : uw.tgt_false) : r_pc;

    // Datapath action; a skip step shifts only while a leading zero remains above the last digit
    always_comb begin
        if (!fire) begin
            dp_ctrl.act = ACT_NONE;
        end else if (uw.act == ACT_SKIP) begin
            dp_ctrl.act = cond_true ? ACT_SHIFT : ACT_NONE;
        end else begin
            dp_ctrl.act = uw.act;
        end
    end

    itaf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_ctrl      (dp_ctrl),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_status    (st)
    );

    // Output register
    always_comb begin
        n_o_valid   = r_o_valid && !i_ready;
        n_character = r_character;
        n_last      = r_last;
        if (fire && (uw.emit != EMIT_NONE)) begin
            n_o_valid = 1'b1;
            n_last    = (uw.emit == EMIT_DIGIT) && !st.cnt_more;
            unique case (uw.emit)
                EMIT_MINUS: n_character = CH_MINUS;
                EMIT_ZERO:  n_character = CH_ZERO;
                EMIT_X:     n_character = CH_X;
                default:    n_character = hex_char(st.nibble, st.upper);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= STEP_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_o_valid <= n_o_valid;
        end
        r_character <= n_character;
        r_last      <= n_last;
    end

    assign o_ready     = (r_pc == STEP_IDLE);
    assign o_valid     = r_o_valid;
    assign o_character = r_character;
    assign o_last      = r_last;

    // An unused operation code is dropped without leaving idle
    a_bad_op_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && bad_op) |=> (r_pc == STEP_IDLE))
        else $error("unused operation code left the idle step");

    // The final digit returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (uw.emit == EMIT_DIGIT) && !st.cnt_more) |=> (r_pc == STEP_IDLE))
        else $error("sequencer did not return to idle after the last digit");

    // An emit step holds while the output register is occupied
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc != STEP_IDLE) && (uw.emit != EMIT_NONE) && r_o_valid && !i_ready)
        |=> $stable(r_pc))
        else $error("emit step advanced while the output was stalled");

endmodule

[dv/integer_to_ascii_formatter_core_tb.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_tb
// Self-checking bench for the integer to ASCII formatter. A driver offers
// format requests from a queue that the stimulus block fills. Each accepted
// request is turned into the characters it should produce. A monitor checks
// every character and last flag against those predictions, in order. Both
// sides idle at random. The receiver takes one long break so that the
// block backs up, and the sender stops now and then until the output drains.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core_tb;
    import itaf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RANDOM_REQS   = 480;
    localparam int MAX_GAP       = 18;
    localparam int LONG_HOLD     = 400;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 60;

    // Codes the block accepts and drops without output
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] value;
        logic        drain_first;   // hold this request until output drains
    } t_fmt_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } t_fmt_char;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [2:0]  i_operation = OP_SDEC;
    logic [63:0] i_value     = 64'd0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_character;
    logic        o_last;

    t_fmt_req  pending_reqs[$];
    t_fmt_char due_chars[$];
    t_fmt_req  head_req;
    t_fmt_char want;

    int  errors      = 0;
    int  chars_seen  = 0;
    int  idle_cycles = 0;
    bit  req_taken   = 1'b0;
    bit  char_taken  = 1'b0;
    bit  offering    = 1'b0;
    int  send_wait   = 0;
    int  recv_wait   = 0;
    bit  send_calm   = 1'b0;
    bit  recv_calm   = 1'b1;
    logic long_hold  = 1'b0;

    integer_to_ascii_formatter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Text the block should emit for one request, queued in output order
    function automatic void format_number(input logic [2:0] op, input logic [63:0] val);
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        logic [63:0] mag;
        logic [63:0] radix;
        logic [63:0] d;
        logic        upcase;
        t_fmt_char   c;
        radix  = 64'd16;
        upcase = 1'b0;
        mag    = {32'd0, val[31:0]};
        case (op)
            OP_SDEC: begin
                radix = 64'd10;
                if (val[31]) begin
                    text.push_back(CH_MINUS);
                    mag = {32'd0, (~val[31:0]) + 32'd1};
                end
            end
            OP_UDEC: radix = 64'd10;
            OP_LHEX: upcase = 1'b0;
            OP_UHEX: upcase = 1'b1;
            OP_PTR: begin
                text.push_back(CH_ZERO);
                text.push_back(CH_X);
                mag = val;
            end
            default: return;
        endcase
        // least significant digit first, so build the digit string backwards
        do begin
            d = mag % radix;
            if (d < 64'd10) begin
                digits.push_front(CH_ZERO + d[7:0]);
            end else if (upcase) begin
                digits.push_front(CH_UPA + d[7:0] - 8'd10);
            end else begin
                digits.push_front(CH_LOWA + d[7:0] - 8'd10);
            end
            mag = mag / radix;
        end while (mag != 64'd0);
        foreach (digits[i]) text.push_back(digits[i]);
        foreach (text[i]) begin
            c.ch      = text[i];
            c.is_last = (i == text.size() - 1);
            due_chars.push_back(c);
        end
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] wanted);
        errors++;
        $display("MISMATCH %s: got %02h, expected %02h (output %0d)",
                 what, got, wanted, chars_seen);
    endtask

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void add_req(input logic [2:0] op, input logic [63:0] val,
                                    input logic drain);
        t_fmt_req r;
        r.op          = op;
        r.value       = val;
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endfunction

    // Request driver: new payload at the falling edge, held until taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (offering && req_taken) begin
                offering  = 1'b0;
                send_wait = draw_gap(send_calm);
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            end
            req_taken = 1'b0;
            if (!offering) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_reqs.size() > 0) begin
                    if (!(pending_reqs[0].drain_first && due_chars.size() != 0)) begin
                        head_req = pending_reqs.pop_front();
                        offering = 1'b1;
                        i_operation <= head_req.op;
                        i_value     <= head_req.value;
                    end
                end
            end
            i_valid <= offering;
        end
    end

    // Output side: random stalls per character, plus one long break
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (char_taken) begin
                char_taken = 1'b0;
                recv_wait  = draw_gap(recv_calm);
                if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !long_hold;
            end
        end
    end

    initial begin
        wait (chars_seen >= 300);
        @(negedge i_clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(negedge i_clk);
        long_hold <= 1'b0;
    end

    // Monitor: predict on each accepted request, check each character
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (i_valid && o_ready) begin
                format_number(i_operation, i_value);
                req_taken   = 1'b1;
                idle_cycles = 0;
            end
            if (o_valid && i_ready) begin
                char_taken  = 1'b1;
                idle_cycles = 0;
                chars_seen++;
                if (due_chars.size() == 0) begin
                    note_mismatch("unexpected character", o_character, 8'd0);
                end else begin
                    want = due_chars.pop_front();
                    if (o_character !== want.ch)
                        note_mismatch("character", o_character, want.ch);
                    if (o_last !== want.is_last)
                        note_mismatch("last flag", {7'd0, o_last}, {7'd0, want.is_last});
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int          count;
        logic [2:0]  op;
        logic [63:0] v;

        // directed: extremes, every form, spare codes
        add_req(OP_SDEC, 64'd0, 1'b0);
        add_req(OP_SDEC, 64'd1, 1'b0);
        add_req(OP_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b0);
        add_req(OP_SDEC, 64'h0000_0000_8000_0000, 1'b0);
        add_req(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_req(OP_SDEC, 64'hFFFF_FFFF_0000_0005, 1'b0);
        add_req(OP_UDEC, 64'd0, 1'b0);
        add_req(OP_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b0);
        add_req(OP_UDEC, 64'd1000000000, 1'b0);
        add_req(OP_UDEC, 64'hDEAD_BEEF_0000_000A, 1'b0);
        add_req(OP_LHEX, 64'd0, 1'b0);
        add_req(OP_LHEX, 64'h0000_0000_ABCD_EF09, 1'b0);
        add_req(OP_LHEX, 64'h1234_5678_FFFF_FFFF, 1'b0);
        add_req(OP_UHEX, 64'd0, 1'b0);
        add_req(OP_UHEX, 64'h0000_0000_ABCD_EF09, 1'b0);
        add_req(OP_UHEX, 64'h0000_0000_0000_000F, 1'b0);
        add_req(OP_PTR,  64'd0, 1'b0);
        add_req(OP_PTR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_req(OP_PTR,  64'h8000_0000_0000_0000, 1'b0);
        add_req(OP_PTR,  64'd1, 1'b0);
        add_req(OP_PTR,  64'h0FED_CBA9_8765_4321, 1'b0);
        add_req(OP_SPARE5, 64'h0000_0000_0000_0007, 1'b0);
        add_req(OP_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_req(OP_SPARE7, 64'd0, 1'b0);
        add_req(OP_UDEC, 64'd42, 1'b1);

        // random: mixed value shapes, a few spare codes, occasional drains
        count = 0;
        while (count < RANDOM_REQS) begin
            case ($urandom_range(0, 9))
                0:       v = 64'd0;
                1:       v = 64'($urandom_range(0, 20));
                2:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
                3:       v = {$urandom, 32'h8000_0000 | $urandom};
                4:       v = ~64'd0 >> $urandom_range(0, 63);
                default: v = {$urandom, $urandom};
            endcase
            if ($urandom_range(0, 24) == 0) begin
                op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
            end else begin
                op = 3'($urandom_range(OP_SDEC, OP_PTR));
                count++;
            end
            add_req(op, v, $urandom_range(0, 59) == 0);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || offering || due_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
design/itaf_pkg.sv
design/itaf_datapath.sv
design/integer_to_ascii_formatter_core.sv
dv/integer_to_ascii_formatter_core_tb.sv
